[src/bbun_pkg.sv]
package bbun_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // unit_scale is unsigned Q16.32
  localparam int SCALE_WIDTH = 48;
  localparam int SCALE_FRAC  = 32;
  localparam logic [SCALE_WIDTH-1:0] SCALE_MAX = '1;

  localparam int AXES        = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQ_LOAD,
    B_SQ_RUN,
    B_SQ_ADD,
    B_CHECK,
    B_DIV,
    B_ROOT_INIT,
    B_ROOT,
    B_SAT,
    B_CT_LOAD,
    B_CT_RUN,
    B_CT_FIX,
    B_OUTPUT
  } back_state_t;

endpackage

[src/bbun_point_if.sv]
interface bbun_point_if #(
  parameter int COORD_WIDTH = bbun_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic                          first_point;
  logic                          last_point;

  modport source (
    output valid, point_x, point_y, point_z, first_point, last_point,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, first_point, last_point,
    output ready
  );
endinterface

[src/bbun_result_if.sv]
interface bbun_result_if #(
  parameter int COORD_WIDTH = bbun_pkg::COORD_WIDTH_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic [bbun_pkg::SCALE_WIDTH-1:0]      unit_scale;
  logic signed [COORD_WIDTH-1:0]         center_x;
  logic signed [COORD_WIDTH-1:0]         center_y;
  logic signed [COORD_WIDTH-1:0]         center_z;
  logic                                  degenerate;
  logic                                  clipped;

  modport source (
    output valid, unit_scale, center_x, center_y, center_z, degenerate, clipped,
    input  ready
  );

  modport sink (
    input  valid, unit_scale, center_x, center_y, center_z, degenerate, clipped,
    output ready
  );
endinterface

[src/bbun_front.sv]
module bbun_front #(
  parameter int COORD_WIDTH = bbun_pkg::COORD_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  bbun_point_if.sink                                  point,
  output logic                                        push,
  output logic [2*bbun_pkg::AXES*COORD_WIDTH-1:0]     entry,
  input  logic                                        full
);

  localparam int W = COORD_WIDTH;
  localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] bmin [bbun_pkg::AXES];
  logic signed [W-1:0] bmax [bbun_pkg::AXES];
  logic signed [W-1:0] pnt      [bbun_pkg::AXES];
  logic signed [W-1:0] min_next [bbun_pkg::AXES];
  logic signed [W-1:0] max_next [bbun_pkg::AXES];
  logic                xfer;

  assign point.ready = !full;
  assign xfer        = point.valid && point.ready;

  assign pnt[0] = point.point_x;
  assign pnt[1] = point.point_y;
  assign pnt[2] = point.point_z;

  always_comb begin
    for (int a = 0; a < bbun_pkg::AXES; a++) begin
      if (point.first_point) begin
        min_next[a] = pnt[a];
        max_next[a] = pnt[a];
      end else begin
        min_next[a] = (pnt[a] < bmin[a]) ? pnt[a] : bmin[a];
        max_next[a] = (pnt[a] > bmax[a]) ? pnt[a] : bmax[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < bbun_pkg::AXES; a++) begin
        bmin[a] <= MOST_POS;
        bmax[a] <= MOST_NEG;
      end
    end else if (xfer) begin
      for (int a = 0; a < bbun_pkg::AXES; a++) begin
        bmin[a] <= min_next[a];
        bmax[a] <= max_next[a];
      end
    end
  end

  // the box including the current point goes to the back end
  assign push  = xfer && point.last_point;
  assign entry = {max_next[2], max_next[1], max_next[0],
                  min_next[2], min_next[1], min_next[0]};

endmodule

[src/bbun_fifo.sv]
module bbun_fifo #(
  parameter int WIDTH = 6 * bbun_pkg::COORD_WIDTH_DEF,
  parameter int DEPTH = bbun_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[src/bbun_back.sv]
module bbun_back #(
  parameter int COORD_WIDTH   = bbun_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = bbun_pkg::FRACTION_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        empty,
  output logic                                        pop,
  input  logic [2*bbun_pkg::AXES*COORD_WIDTH-1:0]     entry,
  bbun_result_if.source                               result
);

  localparam int W    = COORD_WIDTH;
  localparam int SCW  = bbun_pkg::SCALE_WIDTH;
  localparam int MA   = W + 1;                       // multiplicand width
  localparam int MB   = (SCW > W) ? SCW : W;         // serial multiplier width
  localparam int PRW  = MA + MB;
  localparam int SW   = 2 * W + 2;                   // sum of squares
  localparam int PEXP = 2 * bbun_pkg::SCALE_FRAC + 2 * FRACTION_BITS;
  localparam int QW   = PEXP + 1;                    // quotient of 2^PEXP / S
  localparam int XW   = QW + 1;                      // QW is odd: pad to even
  localparam int RW   = XW / 2;                      // root width
  localparam int EW   = (RW > SCW) ? RW : SCW;
  localparam int CSH  = bbun_pkg::SCALE_FRAC + 1;
  localparam int BW   = PRW + 1;
  localparam int QCW  = BW - CSH;
  localparam int CM1  = (MB > QW) ? MB : QW;
  localparam int CMAX = (CM1 > RW) ? CM1 : RW;
  localparam int CNTW = $clog2(CMAX);

  localparam logic [BW-1:0]  CBIAS    = {{(BW-CSH){1'b0}}, {CSH{1'b1}}};
  localparam logic [QCW-1:0] CHALF    = {{(QCW-1){1'b0}}, 1'b1} << (W - 1);
  localparam logic [W-1:0]   MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   MOST_NEG = {1'b1, {(W-1){1'b0}}};

  bbun_pkg::back_state_t state, state_next;

  logic [1:0]          axis;
  logic [CNTW-1:0]     cnt;
  logic signed [W-1:0] bmin [bbun_pkg::AXES];
  logic signed [W-1:0] bmax [bbun_pkg::AXES];
  logic [SW-1:0]       s;
  logic [MA-1:0]       mul_a;
  logic [PRW-1:0]      prod;
  logic [SW-1:0]       rem;
  logic [QW-1:0]       quo;
  logic [XW-1:0]       xsh;
  logic [RW+1:0]       srem;
  logic [RW-1:0]       root;
  logic [SCW-1:0]      scale;
  logic                degen;
  logic                clip;
  logic [W-1:0]        cen [bbun_pkg::AXES];

  // axis datapath
  logic [W-1:0]        diff;
  logic signed [W:0]   sum;
  logic                sum_neg;
  logic [MA-1:0]       mag;

  // shift-add multiplier step
  logic [MA:0]         addv;
  logic [MA:0]         top;
  logic [PRW-1:0]      prod_step;

  // restoring divider step
  logic [SW:0]         rem_sh;
  logic                dge;
  logic [SW-1:0]       rem_step;

  // restoring square root step
  logic [RW+2:0]       srem_sh;
  logic [RW+2:0]       trial;
  logic                sge;
  logic [RW+1:0]       srem_step;

  // saturation and center rounding
  logic [EW-1:0]       root_ext;
  logic [SCW-1:0]      scale_sat;
  logic [BW-1:0]       biased;
  logic [QCW-1:0]      qc;
  logic                cclip;
  logic [W-1:0]        cval;

  always_comb begin
    diff    = W'(bmax[axis] - bmin[axis]);
    sum     = {bmin[axis][W-1], bmin[axis]} + {bmax[axis][W-1], bmax[axis]};
    sum_neg = sum[W];
    mag     = sum_neg ? MA'(-sum) : MA'(sum);
  end

  always_comb begin
    addv      = prod[0] ? {1'b0, mul_a} : '0;
    top       = {1'b0, prod[PRW-1:MB]} + addv;
    prod_step = {top, prod[MB-1:1]};
  end

  always_comb begin
    rem_sh   = {rem, (cnt == CNTW'(PEXP))};
    dge      = (rem_sh >= {1'b0, s});
    rem_step = dge ? SW'(rem_sh - {1'b0, s}) : rem_sh[SW-1:0];
  end

  always_comb begin
    srem_sh   = {srem[RW:0], xsh[XW-1:XW-2]};
    trial     = {1'b0, root, 2'b01};
    sge       = (srem_sh >= trial);
    srem_step = sge ? (RW+2)'(srem_sh - trial) : srem_sh[RW+1:0];
  end

  always_comb begin
    root_ext  = EW'(root);
    scale_sat = (root_ext > EW'(bbun_pkg::SCALE_MAX)) ? bbun_pkg::SCALE_MAX
                                                       : root_ext[SCW-1:0];
  end

  // negative sum: floor of a positive value; else ceiling, then negate
  always_comb begin
    biased = {1'b0, prod} + (sum_neg ? '0 : CBIAS);
    qc     = biased[BW-1:CSH];
    if (sum_neg) begin
      cclip = (qc > CHALF - 1'b1);
      cval  = cclip ? MOST_POS : qc[W-1:0];
    end else begin
      cclip = (qc > CHALF);
      cval  = cclip ? MOST_NEG : W'(-qc[W-1:0]);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bbun_pkg::B_IDLE:      if (!empty) state_next = bbun_pkg::B_SQ_LOAD;
      bbun_pkg::B_SQ_LOAD:   state_next = bbun_pkg::B_SQ_RUN;
      bbun_pkg::B_SQ_RUN:    if (cnt == '0) state_next = bbun_pkg::B_SQ_ADD;
      bbun_pkg::B_SQ_ADD:    state_next = (axis == 2'd2) ? bbun_pkg::B_CHECK
                                                         : bbun_pkg::B_SQ_LOAD;
      bbun_pkg::B_CHECK:     state_next = (s == '0) ? bbun_pkg::B_CT_LOAD
                                                    : bbun_pkg::B_DIV;
      bbun_pkg::B_DIV:       if (cnt == '0) state_next = bbun_pkg::B_ROOT_INIT;
      bbun_pkg::B_ROOT_INIT: state_next = bbun_pkg::B_ROOT;
      bbun_pkg::B_ROOT:      if (cnt == '0) state_next = bbun_pkg::B_SAT;
      bbun_pkg::B_SAT:       state_next = bbun_pkg::B_CT_LOAD;
      bbun_pkg::B_CT_LOAD:   state_next = bbun_pkg::B_CT_RUN;
      bbun_pkg::B_CT_RUN:    if (cnt == '0) state_next = bbun_pkg::B_CT_FIX;
      bbun_pkg::B_CT_FIX:    state_next = (axis == 2'd2) ? bbun_pkg::B_OUTPUT
                                                         : bbun_pkg::B_CT_LOAD;
      bbun_pkg::B_OUTPUT:    if (result.ready) state_next = bbun_pkg::B_IDLE;
      default:               state_next = bbun_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop          = (state == bbun_pkg::B_IDLE) && !empty;
    result.valid = (state == bbun_pkg::B_OUTPUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bbun_pkg::B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      bbun_pkg::B_IDLE: begin
        if (!empty) begin
          for (int a = 0; a < bbun_pkg::AXES; a++) begin
            bmin[a] <= entry[a*W +: W];
            bmax[a] <= entry[(bbun_pkg::AXES + a)*W +: W];
          end
        end
        axis <= '0;
        s    <= '0;
        clip <= 1'b0;
      end
      bbun_pkg::B_SQ_LOAD: begin
        mul_a <= MA'(diff);
        prod  <= {{MA{1'b0}}, MB'(diff)};
        cnt   <= CNTW'(MB - 1);
      end
      bbun_pkg::B_SQ_RUN, bbun_pkg::B_CT_RUN: begin
        prod <= prod_step;
        cnt  <= cnt - 1'b1;
      end
      bbun_pkg::B_SQ_ADD: begin
        s    <= s + {2'b00, prod[2*W-1:0]};
        axis <= (axis == 2'd2) ? 2'd0 : axis + 1'b1;
      end
      bbun_pkg::B_CHECK: begin
        degen <= (s == '0);
        scale <= bbun_pkg::SCALE_MAX;
        rem   <= '0;
        quo   <= '0;
        cnt   <= CNTW'(PEXP);
      end
      bbun_pkg::B_DIV: begin
        rem <= rem_step;
        quo <= {quo[QW-2:0], dge};
        cnt <= cnt - 1'b1;
      end
      bbun_pkg::B_ROOT_INIT: begin
        xsh  <= {1'b0, quo};
        srem <= '0;
        root <= '0;
        cnt  <= CNTW'(RW - 1);
      end
      bbun_pkg::B_ROOT: begin
        srem <= srem_step;
        root <= {root[RW-2:0], sge};
        xsh  <= {xsh[XW-3:0], 2'b00};
        cnt  <= cnt - 1'b1;
      end
      bbun_pkg::B_SAT: begin
        scale <= scale_sat;
      end
      bbun_pkg::B_CT_LOAD: begin
        mul_a <= mag;
        prod  <= {{MA{1'b0}}, MB'(scale)};
        cnt   <= CNTW'(MB - 1);
      end
      bbun_pkg::B_CT_FIX: begin
        cen[axis] <= cval;
        clip      <= clip | cclip;
        axis      <= (axis == 2'd2) ? 2'd0 : axis + 1'b1;
      end
      default: ;
    endcase
  end

  assign result.unit_scale = scale;
  assign result.center_x   = cen[0];
  assign result.center_y   = cen[1];
  assign result.center_z   = cen[2];
  assign result.degenerate = degen;
  assign result.clipped    = clip;

endmodule

[src/bounding_box_unit_normalizer.sv]
// Points: one transfer per cycle; ready drops only while the box queue (two entries) is full.
// The back end squares each span in a bit-serial multiplier of width MB = max(48, COORD_WIDTH),
// divides 2^PEXP by the sum of squares in a restoring divider, PEXP = 64 + 2*FRACTION_BITS,
// and takes a restoring square root of width RW = PEXP/2 + 1; the multiplier then scales the centers.
// A zero diagonal skips the divide and root. One result is in flight in the back end at a time.
// Synchronous reset empties the queue, idles the back end and sets the empty-box bounds.
module bounding_box_unit_normalizer #(
  parameter int COORD_WIDTH   = bbun_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = bbun_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bbun_point_if.sink    point,
  bbun_result_if.source result
);

  localparam int EW = 2 * bbun_pkg::AXES * COORD_WIDTH;

  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;

  bbun_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .point (point),
    .push  (push),
    .entry (wdata),
    .full  (full)
  );

  bbun_fifo #(
    .WIDTH(EW),
    .DEPTH(bbun_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .full  (full),
    .pop   (pop),
    .rdata (rdata),
    .empty (empty)
  );

  bbun_back #(
    .COORD_WIDTH  (COORD_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .pop    (pop),
    .entry  (rdata),
    .result (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("box queue written while full");

  a_push_fills: assert property (@(posedge clk) disable iff (rst) push |=> !empty)
    else $error("box queue empty after a write");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("box queue read while empty");

  a_degen_scale: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.degenerate) |-> (result.unit_scale == bbun_pkg::SCALE_MAX))
    else $error("degenerate box without saturated scale");

endmodule

[tb/bounding_box_unit_normalizer_tb.sv]
module bounding_box_unit_normalizer_tb;

  localparam int RANDOM_POINTS  = 1250;
  localparam int IDLE_PERCENT   = 31;
  localparam int RESULT_LATENCY = 6 * 48 + 96 + 49 + 18;
  localparam int CYCLE_LIMIT    = 3000000;
  localparam int RECIP_EXP      = 64 + 2 * bbun_pkg::FRACTION_BITS_DEF;
  localparam int CENTER_SHIFT   = bbun_pkg::SCALE_FRAC + 1;
  localparam int CW             = bbun_pkg::COORD_WIDTH_DEF;
  localparam int SW             = bbun_pkg::SCALE_WIDTH;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [127:0] COORD_HALF = 128'd1 << (CW - 1);

  typedef struct {
    logic [SW-1:0] unit_scale;
    coord_t        center[bbun_pkg::AXES];
    logic          degenerate;
    logic          clipped;
  } box_result_t;

  typedef enum int {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_FLAT, SPREAD_CORNER} spread_t;

  logic clk;
  logic rst;

  bbun_point_if  #(.COORD_WIDTH(CW)) point_bus ();
  bbun_result_if #(.COORD_WIDTH(CW)) result_bus ();

  bounding_box_unit_normalizer #(
    .COORD_WIDTH  (CW),
    .FRACTION_BITS(bbun_pkg::FRACTION_BITS_DEF)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .point (point_bus),
    .result(result_bus)
  );

  coord_t      box_lo[bbun_pkg::AXES];
  coord_t      box_hi[bbun_pkg::AXES];
  box_result_t pending_boxes[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          no_idle = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // floor(-(lo+hi) * scale / 2^33), saturated to the coordinate range
  function automatic coord_t scaled_center(coord_t lo, coord_t hi,
                                           logic [SW-1:0] scale, output bit clip);
    logic signed [CW+1:0] sum;
    logic [127:0] mag;
    logic [127:0] quot;
    coord_t       value;
    sum  = lo + hi;
    clip = 1'b0;
    if (sum < 0) begin
      mag  = 128'(-sum);
      quot = (mag * scale) >> CENTER_SHIFT;
      if (quot > COORD_HALF - 1) begin
        clip  = 1'b1;
        value = COORD_MAX;
      end else begin
        value = quot[CW-1:0];
      end
    end else begin
      mag  = 128'(sum);
      // ceiling of the magnitude gives the floor of the negated value
      quot = (mag * scale + ((128'd1 << CENTER_SHIFT) - 1)) >> CENTER_SHIFT;
      if (quot > COORD_HALF) begin
        clip  = 1'b1;
        value = COORD_MIN;
      end else begin
        value = -quot[CW-1:0];
      end
    end
    return value;
  endfunction

  function automatic box_result_t normalize_box();
    box_result_t  res;
    logic [65:0]  sq_sum;
    logic [31:0]  span;
    logic [127:0] quot;
    logic [127:0] trial;
    logic [127:0] root;
    bit           clip;
    int           a;
    int           b;
    sq_sum = '0;
    for (a = 0; a < bbun_pkg::AXES; a++) begin
      span   = 32'(box_hi[a] - box_lo[a]);
      sq_sum = sq_sum + {34'd0, span} * {34'd0, span};
    end
    res.degenerate = (sq_sum == '0);
    if (res.degenerate) begin
      res.unit_scale = bbun_pkg::SCALE_MAX;
    end else begin
      quot = (128'd1 << RECIP_EXP) / 128'(sq_sum);
      root = '0;
      for (b = 63; b >= 0; b--) begin
        trial = root | (128'd1 << b);
        if (trial * trial <= quot) root = trial;
      end
      res.unit_scale = (root > 128'(bbun_pkg::SCALE_MAX)) ? bbun_pkg::SCALE_MAX
                                                          : root[SW-1:0];
    end
    res.clipped = 1'b0;
    for (a = 0; a < bbun_pkg::AXES; a++) begin
      res.center[a] = scaled_center(box_lo[a], box_hi[a], res.unit_scale, clip);
      res.clipped   = res.clipped | clip;
    end
    return res;
  endfunction

  task automatic track_point(coord_t x, coord_t y, coord_t z, bit first, bit last);
    coord_t pt[bbun_pkg::AXES];
    int     a;
    pt[0] = x;
    pt[1] = y;
    pt[2] = z;
    for (a = 0; a < bbun_pkg::AXES; a++) begin
      if (first) begin
        box_lo[a] = pt[a];
        box_hi[a] = pt[a];
      end else begin
        if (pt[a] < box_lo[a]) box_lo[a] = pt[a];
        if (pt[a] > box_hi[a]) box_hi[a] = pt[a];
      end
    end
    if (last) pending_boxes.push_back(normalize_box());
  endtask

  task automatic send_point(coord_t x, coord_t y, coord_t z, bit first, bit last);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      point_bus.valid <= 1'b0;
      @(negedge clk);
    end
    point_bus.valid       <= 1'b1;
    point_bus.point_x     <= x;
    point_bus.point_y     <= y;
    point_bus.point_z     <= z;
    point_bus.first_point <= first;
    point_bus.last_point  <= last;
    do @(posedge clk); while (!point_bus.ready);
    track_point(x, y, z, first, last);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    point_bus.valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string name, logic [SW-1:0] want,
                               logic [SW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    box_result_t want;
    if (pending_boxes.size() == 0) begin
      $error("result transfer with no box pending");
      mismatches++;
    end else begin
      want = pending_boxes.pop_front();
      compare_field("unit_scale", want.unit_scale, result_bus.unit_scale);
      compare_field("center_x", want.center[0], result_bus.center_x);
      compare_field("center_y", want.center[1], result_bus.center_y);
      compare_field("center_z", want.center[2], result_bus.center_z);
      compare_field("degenerate", want.degenerate, result_bus.degenerate);
      compare_field("clipped", want.clipped, result_bus.clipped);
    end
  endtask

  always @(negedge clk) begin
    result_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) check_result();
  end

  function automatic coord_t pick_coord(spread_t spread, coord_t base, int spread_bits);
    coord_t value;
    case (spread)
      SPREAD_FULL:    value = $urandom;
      SPREAD_CLUSTER: value = base + coord_t'($urandom & ((32'd1 << spread_bits) - 1));
      SPREAD_FLAT:    value = base;
      default: begin
        case ($urandom_range(4))
          0:       value = COORD_MAX;
          1:       value = COORD_MIN;
          2:       value = '0;
          3:       value = -1;
          default: value = 1;
        endcase
      end
    endcase
    return value;
  endfunction

  // reset bounds act as an empty box until the first flag shows up
  task automatic test_box_after_reset();
    send_point(32'sh0001_0000, 32'sh0002_0000, 3, 1'b0, 1'b0);
    send_point(-5, 32'sh0007_0000, 0, 1'b0, 1'b0);
    send_point(100, -100, 32'sh0032_0000, 1'b0, 1'b1);
  endtask

  task automatic test_single_point();
    send_point(32'sh1234_5678, -32'sh1000, 0, 1'b1, 1'b1);
    send_point(COORD_MAX, COORD_MIN, -1, 1'b1, 1'b1);
  endtask

  task automatic test_full_range();
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b1);
    send_point(COORD_MAX, COORD_MIN, 0, 1'b1, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 0, 1'b0, 1'b1);
  endtask

  // one raw unit of diagonal: scale saturates without the degenerate flag
  task automatic test_tiny_diagonal();
    send_point(COORD_MAX - 1, 0, 0, 1'b1, 1'b0);
    send_point(COORD_MAX, 0, 0, 1'b0, 1'b1);
    send_point(COORD_MIN, 7, -7, 1'b1, 1'b0);
    send_point(COORD_MIN + 1, 7, -7, 1'b0, 1'b1);
    send_point(0, 0, 0, 1'b1, 1'b0);
    send_point(0, 1, 0, 1'b0, 1'b1);
  endtask

  // points without last only grow the box; a first in mid-mesh restarts it
  task automatic test_open_mesh();
    send_point(10, 10, 10, 1'b1, 1'b0);
    send_point(20, -20, 5, 1'b0, 1'b0);
    send_point(-3, 4, 1, 1'b0, 1'b1);
    send_point(32'sh4000, 32'sh4000, 32'sh4000, 1'b1, 1'b0);
    send_point(-32'sh8000, 0, 32'sh100, 1'b0, 1'b0);
    send_point(32'sh7000, -32'sh10, 0, 1'b1, 1'b0);
    send_point(32'sh7001, 32'sh20, -32'sh30, 1'b0, 1'b1);
  endtask

  task automatic test_random_meshes();
    int      sent;
    int      len;
    int      i;
    int      a;
    int      pick;
    int      spread_bits;
    bit      broken;
    spread_t spread;
    coord_t  base[bbun_pkg::AXES];
    coord_t  c[bbun_pkg::AXES];
    sent = 0;
    while (sent < RANDOM_POINTS) begin
      no_idle = (sent >= 500 && sent < 700);
      broken  = ($urandom_range(9) == 0);
      len     = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      pick    = $urandom_range(99);
      spread  = (pick < 30) ? SPREAD_FULL :
                (pick < 75) ? SPREAD_CLUSTER :
                (pick < 85) ? SPREAD_FLAT : SPREAD_CORNER;
      spread_bits = $urandom_range(0, 20);
      for (a = 0; a < bbun_pkg::AXES; a++) base[a] = $urandom;
      for (i = 0; i < len; i++) begin
        for (a = 0; a < bbun_pkg::AXES; a++) c[a] = pick_coord(spread, base[a], spread_bits);
        if (broken)
          send_point(c[0], c[1], c[2], $urandom_range(1), $urandom_range(1));
        else
          send_point(c[0], c[1], c[2], i == 0, i == len - 1);
        sent++;
      end
    end
    no_idle = 0;
  endtask

  initial begin
    int a;
    rst                   = 1'b1;
    point_bus.valid       = 1'b0;
    point_bus.point_x     = '0;
    point_bus.point_y     = '0;
    point_bus.point_z     = '0;
    point_bus.first_point = 1'b0;
    point_bus.last_point  = 1'b0;
    result_bus.ready      = 1'b0;
    for (a = 0; a < bbun_pkg::AXES; a++) begin
      box_lo[a] = COORD_MAX;
      box_hi[a] = COORD_MIN;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_box_after_reset();
    test_single_point();
    test_full_range();
    wait_for_results();
    test_tiny_diagonal();
    test_open_mesh();
    wait_for_results();
    test_random_meshes();
    wait_for_results();
    repeat (RESULT_LATENCY + 50) @(posedge clk);

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
